// File: sv/perfect_number_test_macros.svh
// Assertion helpers shared by the perfect number test RTL.
`ifndef PERFECT_NUMBER_TEST_MACROS_SVH
`define PERFECT_NUMBER_TEST_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define PNT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define PNT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/pnt_pkg.sv
`default_nettype none

package pnt_pkg;

  // Default width of the tested value
  localparam int VALUE_BITS_DEF = 31;
  // Width of the reported divisor sum
  localparam int SUM_BITS = 34;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_DIV,
    ST_ACC_D,
    ST_ACC_Q,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// File: sv/perfect_number_test.sv
// Perfect number test: one value per command, one result beat per value.
// The value goes through a bit-serial square root, then one divide per candidate
// divisor (root down to 2) with one more accumulate step per hit, then wrap-up.
// busy stays high until the beat is out.
// Rate is set by the single bit-serial restoring divider, one quotient bit a cycle.
// Synchronous active-low reset returns to idle with no result pending.
`default_nettype none

`include "perfect_number_test_macros.svh"

module perfect_number_test #(
  parameter int VALUE_BITS = pnt_pkg::VALUE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [VALUE_BITS-1:0]        in_value,
  output logic                              out_valid,
  output logic                              out_is_perfect,
  output logic [pnt_pkg::SUM_BITS-1:0]      out_divisor_sum
);

  localparam int ROOT_BITS = (VALUE_BITS + 1) / 2;
  localparam int TOP_POS   = 2 * (ROOT_BITS - 1);
  localparam int ACC_RAW   = VALUE_BITS + 3;
  localparam int ACC_BITS  = (ACC_RAW > 64) ? 64 : ACC_RAW;
  localparam int CNT_BITS  = $clog2(VALUE_BITS);
  localparam logic [VALUE_BITS-1:0] BIT_INIT = {{(VALUE_BITS-1){1'b0}}, 1'b1} << TOP_POS;
  localparam logic [CNT_BITS-1:0]   CNT_LAST = CNT_BITS'(VALUE_BITS - 1);
  localparam logic [ROOT_BITS-1:0]  D_TWO    = ROOT_BITS'(2);

  pnt_pkg::state_t state_r, state_nxt;

  logic [VALUE_BITS-1:0] v_r, v_nxt;
  logic [VALUE_BITS-1:0] n_r, n_nxt;
  logic [VALUE_BITS-1:0] res_r, res_nxt;
  logic [VALUE_BITS-1:0] bit_r, bit_nxt;
  logic [VALUE_BITS-1:0] q_r, q_nxt;
  logic [ROOT_BITS-1:0]  rem_r, rem_nxt;
  logic [ROOT_BITS-1:0]  d_r, d_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [ACC_BITS-1:0]   acc_r, acc_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  is_perf_r, is_perf_nxt;
  logic [pnt_pkg::SUM_BITS-1:0] dsum_r, dsum_nxt;

  // Square-root step datapath
  logic [VALUE_BITS:0]   sq_sum;
  logic                  sq_ge;
  // Division step datapath
  logic [ROOT_BITS:0]    trial;
  logic [ROOT_BITS:0]    trial_diff;
  logic                  div_ge;
  logic [ROOT_BITS-1:0]  root;

  assign sq_sum     = {1'b0, res_r} + {1'b0, bit_r};
  assign sq_ge      = ({1'b0, n_r} >= sq_sum);
  assign trial      = {rem_r, q_r[VALUE_BITS-1]};
  assign trial_diff = trial - {1'b0, d_r};
  assign div_ge     = (trial >= {1'b0, d_r});
  assign root       = res_r[ROOT_BITS-1:0];

  // State and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pnt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    v_r       <= v_nxt;
    n_r       <= n_nxt;
    res_r     <= res_nxt;
    bit_r     <= bit_nxt;
    q_r       <= q_nxt;
    rem_r     <= rem_nxt;
    d_r       <= d_nxt;
    cnt_r     <= cnt_nxt;
    acc_r     <= acc_nxt;
    is_perf_r <= is_perf_nxt;
    dsum_r    <= dsum_nxt;
  end

  // Sequencer: square root, then one divide per candidate, then report
  always_comb begin
    logic next_cand;
    next_cand     = 1'b0;
    state_nxt     = state_r;
    v_nxt         = v_r;
    n_nxt         = n_r;
    res_nxt       = res_r;
    bit_nxt       = bit_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    d_nxt         = d_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    out_valid_nxt = 1'b0;
    is_perf_nxt   = is_perf_r;
    dsum_nxt      = dsum_r;

    unique case (state_r)
      pnt_pkg::ST_IDLE: begin
        if (start) begin
          v_nxt     = in_value;
          n_nxt     = in_value;
          res_nxt   = '0;
          bit_nxt   = BIT_INIT;
          state_nxt = pnt_pkg::ST_SQRT;
        end
      end
      pnt_pkg::ST_SQRT: begin
        if (bit_r == '0) begin
          if (v_r == VALUE_BITS'(1)) begin
            acc_nxt   = '0;
            state_nxt = pnt_pkg::ST_DONE;
          end else begin
            acc_nxt = ACC_BITS'(1);
            if (root < D_TWO) begin
              state_nxt = pnt_pkg::ST_DONE;
            end else begin
              d_nxt     = root;
              q_nxt     = v_r;
              rem_nxt   = '0;
              cnt_nxt   = CNT_LAST;
              state_nxt = pnt_pkg::ST_DIV;
            end
          end
        end else begin
          if (sq_ge) begin
            n_nxt   = n_r - sq_sum[VALUE_BITS-1:0];
            res_nxt = (res_r >> 1) + bit_r;
          end else begin
            res_nxt = res_r >> 1;
          end
          bit_nxt = bit_r >> 2;
        end
      end
      pnt_pkg::ST_DIV: begin
        rem_nxt = div_ge ? trial_diff[ROOT_BITS-1:0] : trial[ROOT_BITS-1:0];
        q_nxt   = {q_r[VALUE_BITS-2:0], div_ge};
        if (cnt_r == '0) begin
          state_nxt = pnt_pkg::ST_ACC_D;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      pnt_pkg::ST_ACC_D: begin
        if (rem_r == '0) begin
          acc_nxt   = acc_r + ACC_BITS'(d_r);
          state_nxt = pnt_pkg::ST_ACC_Q;
        end else begin
          next_cand = 1'b1;
        end
      end
      pnt_pkg::ST_ACC_Q: begin
        // a square-root divisor is counted once
        if (q_r != VALUE_BITS'(d_r)) begin
          acc_nxt = acc_r + ACC_BITS'(q_r);
        end
        next_cand = 1'b1;
      end
      pnt_pkg::ST_DONE: begin
        out_valid_nxt = 1'b1;
        is_perf_nxt   = (acc_r == ACC_BITS'(v_r));
        dsum_nxt      = pnt_pkg::SUM_BITS'(acc_r);
        state_nxt     = pnt_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = pnt_pkg::ST_IDLE;
      end
    endcase

    // Step down to the next candidate or finish after 2
    if (next_cand) begin
      if (d_r == D_TWO) begin
        state_nxt = pnt_pkg::ST_DONE;
      end else begin
        d_nxt     = d_r - 1'b1;
        q_nxt     = v_r;
        rem_nxt   = '0;
        cnt_nxt   = CNT_LAST;
        state_nxt = pnt_pkg::ST_DIV;
      end
    end
  end

  assign busy            = (state_r != pnt_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_is_perfect  = is_perf_r;
  assign out_divisor_sum = dsum_r;

  // Checks
  `PNT_ASSERT_NEXT(a_done_beat, state_r == pnt_pkg::ST_DONE, out_valid_r && !busy, "result beat missing after done")
  `PNT_ASSERT_NOW(a_div_floor, state_r == pnt_pkg::ST_DIV, d_r >= D_TWO, "divisor candidate below two")
  `PNT_ASSERT_NOW(a_rem_below, state_r == pnt_pkg::ST_DIV || state_r == pnt_pkg::ST_ACC_D, rem_r < d_r, "partial remainder not below divisor")
  `PNT_ASSERT_NEXT(a_beat_once, out_valid_r, !out_valid_r, "result beat repeated")

endmodule

`default_nettype wire
